// ===== rtl/itt_pkg.sv =====
// Package for the interval timer table: action codes, internal operation
// codes, count width and the command/result/token struct types.
// No dependencies; used by itt_cell and interval_timer_table_top.
package itt_pkg;

    localparam int TIMER_SLOTS_DEF = 8;

    // Running counts inside the chain; 7 bits, wide enough for a table of up to 127 slots.
    localparam int CNT_W = 7;

    localparam int SEC_W   = 16;
    localparam int MICRO_W = 20;
    localparam int OUT_W   = 4;

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(15);

    // Action codes on the command port
    localparam logic [1:0] ACT_ARM   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Decoded operation carried down the chain
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ARM,
        OP_CLEAR,
        OP_TICK
    } itt_op_t;

    typedef struct packed {
        logic [1:0]         action;
        logic               kind_is_virtual;
        logic [SEC_W-1:0]   first_delay_seconds;
        logic [MICRO_W-1:0] first_delay_micros;
        logic [SEC_W-1:0]   reload_seconds;
    } itt_cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] fired_count;
        logic [OUT_W-1:0] active_count;
        logic             table_full;
    } itt_result_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic             vld;
        itt_op_t          op;
        logic [SEC_W-1:0] delay;
        logic [SEC_W-1:0] reload;
        logic             claimed;
        logic [CNT_W-1:0] fired;
        logic [CNT_W-1:0] active;
    } itt_token_t;

endpackage

// ===== rtl/itt_cell.sv =====
// One timer slot of the chain: holds valid, remaining and reload, applies the
// passing token to its slot and hands the updated token to its right neighbor.
// Depends on itt_pkg.
module itt_cell
    import itt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       handler_installed,
    input  itt_token_t tok_in,
    output itt_token_t tok_out
);

    logic             valid_reg,  valid_next;
    logic [SEC_W-1:0] remain_reg, remain_next;
    logic [SEC_W-1:0] reload_reg, reload_next;
    itt_token_t       tok_reg,    tok_next;
    logic [SEC_W-1:0] remain_dec;

    assign remain_dec = remain_reg - SEC_W'(1);

    always_comb
    begin
        valid_next  = valid_reg;
        remain_next = remain_reg;
        reload_next = reload_reg;
        tok_next    = tok_in;
        if (tok_in.vld)
        begin
            case (tok_in.op)
                OP_CLEAR:
                begin
                    valid_next  = 1'b0;
                    remain_next = '0;
                    reload_next = '0;
                end
                OP_ARM:
                begin
                    if (!valid_reg && !tok_in.claimed)
                    begin
                        valid_next       = 1'b1;
                        remain_next      = tok_in.delay;
                        reload_next      = tok_in.reload;
                        tok_next.claimed = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (valid_reg)
                    begin
                        if (remain_reg == '0)
                        begin
                            // sub-second arm: dropped without firing
                            valid_next  = 1'b0;
                            reload_next = '0;
                        end
                        else if (remain_dec == '0)
                        begin
                            if (handler_installed)
                                tok_next.fired = tok_in.fired + CNT_W'(1);
                            if (reload_reg != '0)
                                remain_next = reload_reg;
                            else
                            begin
                                valid_next  = 1'b0;
                                remain_next = '0;
                            end
                        end
                        else
                            remain_next = remain_dec;
                    end
                end
                default:
                begin
                end
            endcase
            tok_next.active = tok_in.active + CNT_W'(valid_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            remain_reg <= '0;
            reload_reg <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            remain_reg <= remain_next;
            reload_reg <= reload_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/interval_timer_table_top.sv =====
// Interval timer table: a row of TIMER_SLOTS timer cells that a command token
// walks through, one cell per cycle, each cell registering the token.
// done is high while the token leaves the last cell; busy drops at the end of
// that cycle, so a new command is only taken once the last one is through.
// Results are a one-cycle strobe; the receiver cannot stall. Reset (rst_n low,
// asynchronous) empties all slots and clears the handler flag. Needs itt_pkg, itt_cell.
module interval_timer_table_top
    import itt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  itt_cmd_t    cmd,
    // result strobe
    output logic        done,
    output itt_result_t result,
    // configuration: handler_installed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int FULL_CNT = (TIMER_SLOTS > 15) ? 15 : TIMER_SLOTS;

    logic       busy_reg, busy_next;
    logic       handler_reg, handler_next;
    logic       accept;
    itt_op_t    op;
    itt_token_t tok [TIMER_SLOTS+1];
    itt_token_t tok_last;
    logic [TIMER_SLOTS-1:0] tok_vld;

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;

    // Configuration register; writes must only arrive while idle, which the block itself does not enforce.
    always_comb
    begin
        handler_next = handler_reg;
        if (cfg_valid && cfg_ready)
            handler_next = cfg_data;
    end

    // Decode the command into the operation the cells apply.
    // An arm with zero delay acts as a clear; arm/clear need a virtual kind.
    always_comb
    begin
        case (cmd.action)
            ACT_ARM:
            begin
                if (!cmd.kind_is_virtual)
                    op = OP_NONE;
                else if (cmd.first_delay_seconds == '0 && cmd.first_delay_micros == '0)
                    op = OP_CLEAR;
                else
                    op = OP_ARM;
            end
            ACT_CLEAR: op = cmd.kind_is_virtual ? OP_CLEAR : OP_NONE;
            ACT_TICK:  op = OP_TICK;
            default:   op = OP_NONE;
        endcase
    end

    // Token entering the first cell
    always_comb
    begin
        tok[0]         = '0;
        tok[0].vld     = accept;
        tok[0].op      = op;
        tok[0].delay   = cmd.first_delay_seconds;
        tok[0].reload  = cmd.reload_seconds;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TIMER_SLOTS; gi++)
        begin : g_cell
            itt_cell u_cell (
                .clk               (clk),
                .rst_n             (rst_n),
                .handler_installed (handler_reg),
                .tok_in            (tok[gi]),
                .tok_out           (tok[gi+1])
            );
            assign tok_vld[gi] = tok[gi+1].vld;
        end
    endgenerate

    assign tok_last = tok[TIMER_SLOTS];

    // Busy from the start transfer until the token leaves the last cell
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (tok_last.vld)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            handler_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            handler_reg <= handler_next;
        end
    end

    assign busy = busy_reg;
    assign done = tok_last.vld;

    // Counts saturate at 15 on the result port
    always_comb
    begin
        result.fired_count  = (tok_last.fired >= CNT_SAT) ? OUT_W'(15)
                                                          : tok_last.fired[OUT_W-1:0];
        result.active_count = (tok_last.active >= CNT_SAT) ? OUT_W'(15)
                                                           : tok_last.active[OUT_W-1:0];
        result.table_full   = (tok_last.op == OP_ARM) && !tok_last.claimed;
    end

    // At most one command in the chain at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell chain");

    // A result only appears while a command is outstanding
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // A start transfer holds off further commands
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after start transfer");

    // A dropped arm means every slot was occupied
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (result.active_count == OUT_W'(FULL_CNT)))
        else $error("table_full with a free slot");

endmodule

// ===== dv/itt_checker.sv =====
// Checker for the interval timer table: tracks the timer slots and the handler
// flag from the command and config transfers, and compares every result strobe.
// Depends on itt_pkg.
`timescale 1ns / 1ps

module itt_checker
    import itt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  itt_cmd_t    cmd,
    input  logic        done,
    input  itt_result_t result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          errors,
    output int          outstanding
);

    localparam int COUNT_MAX = (1 << OUT_W) - 1;

    logic                   handler_on;
    logic [TIMER_SLOTS-1:0] live;
    logic [SEC_W-1:0]       left_sec   [TIMER_SLOTS];
    logic [SEC_W-1:0]       period_sec [TIMER_SLOTS];
    itt_result_t            predicted_counts [$];

    task automatic flag_error(input string msg);
        $display("%0t itt_checker: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [OUT_W-1:0] clamp_count(input int n);
        return (n > COUNT_MAX) ? OUT_W'(COUNT_MAX) : OUT_W'(n);
    endfunction

    function automatic void empty_table();
        live = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            left_sec[i]   = '0;
            period_sec[i] = '0;
        end
    endfunction

    // Applies one command to the slot copy and returns the result it causes.
    function automatic itt_result_t apply_timer_cmd(input itt_cmd_t c);
        itt_result_t r;
        int          fired;
        int          pick;
        r     = '0;
        fired = 0;
        pick  = -1;
        if (c.action == ACT_ARM && c.kind_is_virtual)
        begin
            if (c.first_delay_seconds == '0 && c.first_delay_micros == '0)
            begin
                empty_table();
            end
            else
            begin
                for (int i = TIMER_SLOTS - 1; i >= 0; i--)
                    if (!live[i])
                        pick = i;
                if (pick < 0)
                begin
                    r.table_full = 1'b1;
                end
                else
                begin
                    live[pick]       = 1'b1;
                    left_sec[pick]   = c.first_delay_seconds;
                    period_sec[pick] = c.reload_seconds;
                end
            end
        end
        else if (c.action == ACT_CLEAR && c.kind_is_virtual)
        begin
            empty_table();
        end
        else if (c.action == ACT_TICK)
        begin
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                if (live[i])
                begin
                    if (left_sec[i] == '0)
                    begin
                        // sub-second arm: dropped silently
                        live[i]       = 1'b0;
                        period_sec[i] = '0;
                    end
                    else
                    begin
                        left_sec[i] = left_sec[i] - SEC_W'(1);
                        if (left_sec[i] == '0)
                        begin
                            if (handler_on)
                                fired++;
                            if (period_sec[i] != '0)
                                left_sec[i] = period_sec[i];
                            else
                                live[i] = 1'b0;
                        end
                    end
                end
            end
        end
        r.fired_count  = clamp_count(fired);
        r.active_count = clamp_count($countones(live));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        itt_result_t want;
        if (!rst_n)
        begin
            handler_on = 1'b0;
            empty_table();
            predicted_counts.delete();
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (predicted_counts.size() == 0)
                begin
                    flag_error("result strobe with nothing expected");
                end
                else
                begin
                    want = predicted_counts.pop_front();
                    if (result.fired_count !== want.fired_count)
                        flag_error($sformatf("fired_count %0d, expected %0d",
                                             result.fired_count, want.fired_count));
                    if (result.active_count !== want.active_count)
                        flag_error($sformatf("active_count %0d, expected %0d",
                                             result.active_count, want.active_count));
                    if (result.table_full !== want.table_full)
                        flag_error($sformatf("table_full %b, expected %b",
                                             result.table_full, want.table_full));
                end
            end
            if (cfg_valid && cfg_ready)
                handler_on = cfg_data;
            if (start && !busy)
                predicted_counts.insert(predicted_counts.size(), apply_timer_cmd(cmd));
        end
        outstanding = predicted_counts.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for interval_timer_table_top: drives commands and handler
// writes, and gives the verdict from the checker's counts.
// Depends on itt_pkg, interval_timer_table_top and itt_checker.
`timescale 1ns / 1ps

module tb;
    import itt_pkg::*;

    localparam int SLOTS         = TIMER_SLOTS_DEF;
    localparam logic [1:0] ACT_SPARE = 2'd3;   // undefined action code
    localparam int RANDOM_ITEMS  = 700;
    localparam int PHASES        = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = SLOTS + 4;
    localparam int MICRO_MAX     = 999999;
    localparam int SEC_MAX       = 65535;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    itt_cmd_t    cmd       = '0;
    logic        done;
    itt_result_t result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;   // transfers left in the current burst

    always #1 clk = ~clk;

    interval_timer_table_top #(.TIMER_SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    itt_checker #(.TIMER_SLOTS(SLOTS)) timer_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    function automatic itt_cmd_t make_cmd(input logic [1:0] act, input logic virt,
                                          input int dsec, input int micros,
                                          input int reload);
        itt_cmd_t c;
        c.action              = act;
        c.kind_is_virtual     = virt;
        c.first_delay_seconds = SEC_W'(dsec);
        c.first_delay_micros  = MICRO_W'(micros);
        c.reload_seconds      = SEC_W'(reload);
        return c;
    endfunction

    // Random command. Delays and reloads are mostly a few seconds so timers
    // actually expire, reload and retire within a handful of ticks; clears are
    // rare enough that the table fills up now and then.
    function automatic itt_cmd_t random_cmd();
        itt_cmd_t c;
        int       pick;
        int       sel;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            c.action = ACT_ARM;
        else if (pick < 90)
            c.action = ACT_TICK;
        else if (pick < 96)
            c.action = ACT_CLEAR;
        else
            c.action = ACT_SPARE;
        c.kind_is_virtual = ($urandom_range(0, 9) != 0);
        sel = $urandom_range(0, 19);
        if (sel < 13)
            c.first_delay_seconds = SEC_W'($urandom_range(1, 6));
        else if (sel < 16)
            c.first_delay_seconds = '0;
        else
            c.first_delay_seconds = SEC_W'($urandom_range(0, SEC_MAX));
        if ($urandom_range(0, 7) == 0)
            c.first_delay_micros = '0;
        else
            c.first_delay_micros = MICRO_W'($urandom_range(0, MICRO_MAX));
        sel = $urandom_range(0, 9);
        if (sel < 3)
            c.reload_seconds = '0;
        else if (sel < 8)
            c.reload_seconds = SEC_W'($urandom_range(1, 5));
        else
            c.reload_seconds = SEC_W'($urandom_range(0, SEC_MAX));
        return c;
    endfunction

    // Called at a falling edge. Holds start until the transfer, then applies
    // the burst/gap pacing. start is only lowered when a real gap follows, so
    // it never gets two updates in one time step.
    task automatic send_cmd(input itt_cmd_t c);
        int gap;
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Every command yields one result, so the block is idle once the
    // checker has nothing left outstanding.
    task automatic quiesce();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_handler(input logic v);
        quiesce();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, one-shot, sub-second, max delay, periodic
        write_handler(1'b1);
        send_cmd(make_cmd(ACT_TICK, 1'b0, 0, 0, 0));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 1, 0, 0));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 0, MICRO_MAX, SEC_MAX));
        send_cmd(make_cmd(ACT_ARM, 1'b1, SEC_MAX, 0, SEC_MAX));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 2, 0, 2));
        // non-virtual arm and the spare action code change nothing
        send_cmd(make_cmd(ACT_ARM, 1'b0, 5, 1, 3));
        send_cmd(make_cmd(ACT_SPARE, 1'b1, 7, 7, 7));
        // one-shot fires, sub-second timer retires silently; then periodic fires
        send_cmd(make_cmd(ACT_TICK, 1'b1, 0, 0, 0));
        send_cmd(make_cmd(ACT_TICK, 1'b0, SEC_MAX, MICRO_MAX, SEC_MAX));
        send_cmd(make_cmd(ACT_CLEAR, 1'b0, 0, 0, 0));
        // fill every slot, then one arm too many
        for (int i = 0; i < SLOTS - 2; i++)
            send_cmd(make_cmd(ACT_ARM, 1'b1, i + 3, 1, 1));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 4, 0, 4));
        send_cmd(make_cmd(ACT_TICK, 1'b1, 0, 0, 0));
        // zero delay arm empties the table, but only for the virtual kind
        send_cmd(make_cmd(ACT_ARM, 1'b0, 0, 0, 9));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 0, 0, 9));
        send_cmd(make_cmd(ACT_ARM, 1'b1, 1, 0, 1));
        send_cmd(make_cmd(ACT_CLEAR, 1'b1, SEC_MAX, MICRO_MAX, SEC_MAX));
        // no handler: expiries happen but are not counted
        write_handler(1'b0);
        send_cmd(make_cmd(ACT_ARM, 1'b1, 1, 0, 1));
        send_cmd(make_cmd(ACT_TICK, 1'b1, 0, 0, 0));
        send_cmd(make_cmd(ACT_TICK, 1'b1, 0, 0, 0));

        // random phases; handler flag on, off, on, then random
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                write_handler(logic'($urandom_range(0, 1)));
            else
                write_handler(~p[0]);
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
                send_cmd(random_cmd());
        end

        start <= 1'b0;
        n = 0;
        while (outstanding != 0 && n < DRAIN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
